FILE: rtl/core/reader_writer_lock_arbiter_core_defines.svh
// Assertion macros for the reader/writer lock arbiter core.
// Included by the top level; has no dependencies of its own.
`ifndef READER_WRITER_LOCK_ARBITER_CORE_DEFINES_SVH
`define READER_WRITER_LOCK_ARBITER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication checked at every rising edge outside reset.
`define RWL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define RWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RWL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RWL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/rwl_pkg.sv
// Shared types, constants and pointer helpers of the reader/writer lock arbiter.
// No dependencies; used by rwl_ctrl and the top level.
`default_nettype none

package rwl_pkg;

    // Sizing of the lock and its wait queues.
    localparam int REQUESTERS  = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int ID_W        = 4;
    localparam int CNT_W       = 5;
    localparam int FUNC_W      = 2;
    localparam int EV_W        = 3;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = PTR_W + 1;

    // Request function codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_BEGIN_READ  = 2'd0,
        FN_END_READ    = 2'd1,
        FN_BEGIN_WRITE = 2'd2,
        FN_END_WRITE   = 2'd3
    } func_t;

    // Result event codes.
    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 3'd0,
        EV_READ  = 3'd1,
        EV_WRITE = 3'd2,
        EV_ERROR = 3'd3,
        EV_FULL  = 3'd4
    } ev_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_POP  = 2'b10
    } state_t;

    // One port's worth of requests to a wait-queue memory.
    typedef struct packed {
        logic             wen;
        logic [PTR_W-1:0] waddr;
        logic [ID_W-1:0]  wdata;
        logic             ren;
        logic [PTR_W-1:0] raddr;
    } qmem_req_t;

    // Slot index of head plus offset, wrapped at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] head,
                                                 input logic [FILL_W-1:0] fill);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(head) + SUM_W'(fill);
            if (sum >= SUM_W'(QUEUE_DEPTH))
            begin
                sum = sum - SUM_W'(QUEUE_DEPTH);
            end
            return sum[PTR_W-1:0];
        end
    endfunction

    // Next slot after the given one, wrapped at the queue depth.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] head);
        begin
            if (head == PTR_W'(QUEUE_DEPTH - 1))
            begin
                return '0;
            end
            return head + PTR_W'(1);
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rwl_qram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds one wait queue of the lock arbiter.
`default_nettype none

module rwl_qram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 4
) (
    input  wire logic                                         clk,
    input  wire logic                                         wen,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         ren,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (ren)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/rwl_ctrl.sv
// Lock state, queue pointers, request decode and result register of the arbiter.
// Depends on rwl_pkg; drives the two wait-queue memories through qmem_req_t.
`default_nettype none

module rwl_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [rwl_pkg::FUNC_W-1:0] func,
    input  wire logic [rwl_pkg::ID_W-1:0]   requester_id,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic [rwl_pkg::EV_W-1:0]   event_res,
    output      logic [rwl_pkg::ID_W-1:0]   granted_id,
    output      logic [rwl_pkg::CNT_W-1:0]  active_readers,
    output      logic                       writer_busy,
    output      logic                       last,
    output      rwl_pkg::qmem_req_t         rq_req,
    input  wire logic [rwl_pkg::ID_W-1:0]   rq_rdata,
    output      rwl_pkg::qmem_req_t         wq_req,
    input  wire logic [rwl_pkg::ID_W-1:0]   wq_rdata
);

    import rwl_pkg::*;

    state_t            state_reg, state_next;
    logic              pop_rd_reg, pop_rd_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              wbusy_reg, wbusy_next;
    logic [PTR_W-1:0]  rhead_reg, rhead_next;
    logic [FILL_W-1:0] rfill_reg, rfill_next;
    logic [PTR_W-1:0]  whead_reg, whead_next;
    logic [FILL_W-1:0] wfill_reg, wfill_next;

    logic              out_valid_reg, out_valid_next;
    ev_t               out_ev_reg, out_ev_next;
    logic [ID_W-1:0]   out_id_reg, out_id_next;
    logic [CNT_W-1:0]  out_cnt_reg, out_cnt_next;
    logic              out_wb_reg, out_wb_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic              accept;
    logic              r_full;
    logic              w_full;
    logic [CNT_W-1:0]  count_dec;
    logic [CNT_W-1:0]  count_sat;

    // The result slot is free when empty or being taken this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign r_full    = (rfill_reg == FILL_W'(QUEUE_DEPTH));
    assign w_full    = (wfill_reg == FILL_W'(QUEUE_DEPTH));
    assign count_dec = count_reg - CNT_W'(1);
    assign count_sat = (count_reg < CNT_W'(REQUESTERS)) ? count_reg + CNT_W'(1) : count_reg;

    // Request decode, queue pushes and pops, and result loading.
    always_comb
    begin
        state_next     = state_reg;
        pop_rd_next    = pop_rd_reg;
        count_next     = count_reg;
        wbusy_next     = wbusy_reg;
        rhead_next     = rhead_reg;
        rfill_next     = rfill_reg;
        whead_next     = whead_reg;
        wfill_next     = wfill_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_ev_next    = out_ev_reg;
        out_id_next    = out_id_reg;
        out_cnt_next   = out_cnt_reg;
        out_wb_next    = out_wb_reg;
        out_last_next  = out_last_reg;
        rq_req         = '0;
        wq_req         = '0;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_ev_next    = EV_NONE;
            out_id_next    = '0;
            out_last_next  = 1'b1;
            case (func_t'(func))
                FN_BEGIN_READ:
                begin
                    if (wbusy_reg)
                    begin
                        if (r_full)
                        begin
                            out_ev_next = EV_FULL;
                        end
                        else
                        begin
                            rq_req.wen   = 1'b1;
                            rq_req.waddr = ptr_add(rhead_reg, rfill_reg);
                            rq_req.wdata = requester_id;
                            rfill_next   = rfill_reg + FILL_W'(1);
                        end
                    end
                    else if (count_reg >= CNT_W'(REQUESTERS))
                    begin
                        out_ev_next = EV_ERROR;
                    end
                    else
                    begin
                        count_next  = count_reg + CNT_W'(1);
                        out_ev_next = EV_READ;
                        out_id_next = requester_id;
                    end
                end
                FN_END_READ:
                begin
                    if (count_reg == '0)
                    begin
                        out_ev_next = EV_ERROR;
                    end
                    else
                    begin
                        count_next = count_dec;
                        if ((count_dec == '0) && (wfill_reg != '0))
                        begin
                            // Hand the lock to the oldest writer once its id is read.
                            out_valid_next = 1'b0;
                            wq_req.ren     = 1'b1;
                            wq_req.raddr   = whead_reg;
                            pop_rd_next    = 1'b0;
                            state_next     = ST_POP;
                        end
                    end
                end
                FN_BEGIN_WRITE:
                begin
                    if ((count_reg != '0) || wbusy_reg)
                    begin
                        if (w_full)
                        begin
                            out_ev_next = EV_FULL;
                        end
                        else
                        begin
                            wq_req.wen   = 1'b1;
                            wq_req.waddr = ptr_add(whead_reg, wfill_reg);
                            wq_req.wdata = requester_id;
                            wfill_next   = wfill_reg + FILL_W'(1);
                        end
                    end
                    else
                    begin
                        wbusy_next  = 1'b1;
                        out_ev_next = EV_WRITE;
                        out_id_next = requester_id;
                    end
                end
                FN_END_WRITE:
                begin
                    if (!wbusy_reg)
                    begin
                        out_ev_next = EV_ERROR;
                    end
                    else
                    begin
                        wbusy_next = 1'b0;
                        if (rfill_reg != '0)
                        begin
                            out_valid_next = 1'b0;
                            rq_req.ren     = 1'b1;
                            rq_req.raddr   = rhead_reg;
                            pop_rd_next    = 1'b1;
                            state_next     = ST_POP;
                        end
                        else if (wfill_reg != '0)
                        begin
                            out_valid_next = 1'b0;
                            wq_req.ren     = 1'b1;
                            wq_req.raddr   = whead_reg;
                            pop_rd_next    = 1'b0;
                            state_next     = ST_POP;
                        end
                    end
                end
                default:
                begin
                    out_ev_next = EV_ERROR;
                end
            endcase
        end
        else if ((state_reg == ST_POP) && out_free)
        begin
            // The popped id is in the memory's read register now.
            out_valid_next = 1'b1;
            if (pop_rd_reg)
            begin
                count_next    = count_sat;
                rhead_next    = ptr_inc(rhead_reg);
                rfill_next    = rfill_reg - FILL_W'(1);
                out_ev_next   = EV_READ;
                out_id_next   = rq_rdata;
                out_cnt_next  = count_sat;
                out_wb_next   = wbusy_reg;
                out_last_next = (rfill_reg == FILL_W'(1));
                if (rfill_reg == FILL_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Fetch the next waiting reader for the following cycle.
                    rq_req.ren   = 1'b1;
                    rq_req.raddr = ptr_inc(rhead_reg);
                end
            end
            else
            begin
                wbusy_next    = 1'b1;
                whead_next    = ptr_inc(whead_reg);
                wfill_next    = wfill_reg - FILL_W'(1);
                out_ev_next   = EV_WRITE;
                out_id_next   = wq_rdata;
                out_cnt_next  = count_reg;
                out_wb_next   = 1'b1;
                out_last_next = 1'b1;
                state_next    = ST_IDLE;
            end
        end

        // Immediate results report the lock state after the request.
        if (accept)
        begin
            out_cnt_next = count_next;
            out_wb_next  = wbusy_next;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pop_rd_reg    <= 1'b0;
            count_reg     <= '0;
            wbusy_reg     <= 1'b0;
            rhead_reg     <= '0;
            rfill_reg     <= '0;
            whead_reg     <= '0;
            wfill_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pop_rd_reg    <= pop_rd_next;
            count_reg     <= count_next;
            wbusy_reg     <= wbusy_next;
            rhead_reg     <= rhead_next;
            rfill_reg     <= rfill_next;
            whead_reg     <= whead_next;
            wfill_reg     <= wfill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        out_ev_reg   <= out_ev_next;
        out_id_reg   <= out_id_next;
        out_cnt_reg  <= out_cnt_next;
        out_wb_reg   <= out_wb_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_ev_reg;
    assign granted_id     = out_id_reg;
    assign active_readers = out_cnt_reg;
    assign writer_busy    = out_wb_reg;
    assign last           = out_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/reader_writer_lock_arbiter_core.sv
// Reader/writer lock arbiter: a request needing no queue read returns its result in the
// cycle after acceptance, and the next request can be taken in the following cycle unless
// out_stall holds the result. A grant to a queued requester waits for the queue memory's
// registered read; a drain of N waiting readers gives one grant per cycle unless stalled.
// Reset is asynchronous: it clears the lock state and queue pointers; the queue memories
// are not cleared, since only entries written since reset are ever read.
`default_nettype none

`include "reader_writer_lock_arbiter_core_defines.svh"

module reader_writer_lock_arbiter_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output      logic                       in_stall,
    input  wire logic [rwl_pkg::FUNC_W-1:0] func,
    input  wire logic [rwl_pkg::ID_W-1:0]   requester_id,
    output      logic                       out_valid,
    input  wire logic                       out_stall,
    output      logic [rwl_pkg::EV_W-1:0]   event_res,
    output      logic [rwl_pkg::ID_W-1:0]   granted_id,
    output      logic [rwl_pkg::CNT_W-1:0]  active_readers,
    output      logic                       writer_busy,
    output      logic                       last
);

    import rwl_pkg::*;

    qmem_req_t       rq_req;
    qmem_req_t       wq_req;
    logic [ID_W-1:0] rq_rdata;
    logic [ID_W-1:0] wq_rdata;

    // Lock state machine and result register.
    rwl_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .requester_id   (requester_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .granted_id     (granted_id),
        .active_readers (active_readers),
        .writer_busy    (writer_busy),
        .last           (last),
        .rq_req         (rq_req),
        .rq_rdata       (rq_rdata),
        .wq_req         (wq_req),
        .wq_rdata       (wq_rdata)
    );

    // Waiting-reader queue storage.
    rwl_qram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_W)
    ) u_rq_ram (
        .clk   (clk),
        .wen   (rq_req.wen),
        .waddr (rq_req.waddr),
        .wdata (rq_req.wdata),
        .ren   (rq_req.ren),
        .raddr (rq_req.raddr),
        .rdata (rq_rdata)
    );

    // Waiting-writer queue storage.
    rwl_qram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_W)
    ) u_wq_ram (
        .clk   (clk),
        .wen   (wq_req.wen),
        .waddr (wq_req.waddr),
        .wdata (wq_req.wdata),
        .ren   (wq_req.ren),
        .raddr (wq_req.raddr),
        .rdata (wq_rdata)
    );

    // A writer never shares the lock with readers.
    `RWL_ASSERT_IMP(a_exclusive, clk, rst_n, out_valid && writer_busy, active_readers == '0, "writer and readers hold the lock together")
    // Results that grant nothing carry no requester number.
    `RWL_ASSERT_IMP(a_no_grant_id, clk, rst_n, out_valid && (event_res == EV_NONE || event_res == EV_ERROR || event_res == EV_FULL), granted_id == '0, "non-grant result carries an id")
    // Only a reader drain yields more than one result, and it holds off new requests.
    `RWL_ASSERT_IMP(a_drain_only, clk, rst_n, out_valid && !last, event_res == EV_READ && in_stall, "non-final result outside a reader drain")
    // A begin request always answers in the next cycle.
    `RWL_ASSERT_NEXT(a_begin_answer, clk, rst_n, in_valid && !in_stall && (func == FN_BEGIN_READ || func == FN_BEGIN_WRITE), out_valid && last, "begin request not answered in one cycle")

endmodule

`default_nettype wire
